>>> rtl/ntlv_pkg.sv
package ntlv_pkg;

  // field widths fixed by the interface
  localparam int LEN_W      = 13;
  localparam int BYTE_W     = 8;
  localparam int STAT_W     = 2;
  localparam int AREA_RESET = 96;

  // output queue geometry: room for one worst-case item plus slack
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // TLV codes
  localparam logic [BYTE_W-1:0] TAG_NULL = 8'h00;
  localparam logic [BYTE_W-1:0] TAG_TERM = 8'hFE;
  localparam logic [BYTE_W-1:0] TAG_NDEF = 8'h03;
  localparam logic [BYTE_W-1:0] LEN_LONG = 8'hFF;

  // status codes
  localparam logic [STAT_W-1:0] STAT_FOUND = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NONE  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_TRUNC = 2'd2;

  // result kinds
  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [6:0] {
    PH_TAG    = 7'b0000001,
    PH_LEN    = 7'b0000010,
    PH_LEN_HI = 7'b0000100,
    PH_LEN_LO = 7'b0001000,
    PH_SKIP   = 7'b0010000,
    PH_MSG    = 7'b0100000,
    PH_DONE   = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] mbyte;
    logic [STAT_W-1:0] status;
    logic [LEN_W-1:0]  length;
    logic              last;
  } result_t;

  // results of one processed item, in output order
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

>>> rtl/ntlv_parse.sv
module ntlv_parse #(
  parameter int POS_W = 13
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [POS_W-1:0]           lim,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  logic [ntlv_pkg::BYTE_W-1:0] data_byte,
  input  logic                       first_of_area,
  input  logic                       room,
  output ntlv_pkg::push_t            push
);

  // input register
  logic                        r_valid;
  logic [ntlv_pkg::BYTE_W-1:0] r_byte;
  logic                        r_first;
  logic                        accept;
  logic                        go;

  // parse state
  ntlv_pkg::phase_t            phase, phase_next;
  logic [POS_W-1:0]            pos, pos_next;
  logic [ntlv_pkg::BYTE_W-1:0] tag, tag_next;
  logic [ntlv_pkg::BYTE_W-1:0] lh, lh_next;
  logic [POS_W-1:0]            vr, vr_next;
  logic [POS_W-1:0]            fl, fl_next;

  // working values
  ntlv_pkg::phase_t            ph0;
  logic [POS_W-1:0]            pos0, vr0, fl0, nxt, vr_dec;
  logic [ntlv_pkg::BYTE_W-1:0] tag0, lh0;
  logic [15:0]                 len_sel;
  logic                        over, len_go, emit_byte, emit_stat, fin;
  logic [ntlv_pkg::STAT_W-1:0] stat;
  ntlv_pkg::result_t           byte_r, stat_r;

  assign go         = r_valid && room;
  assign item_stall = r_valid && !room;
  assign accept     = item_valid && !item_stall;

  // input beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (accept) begin
      r_valid <= 1'b1;
    end else if (go) begin
      r_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      r_byte  <= data_byte;
      r_first <= first_of_area;
    end
  end

  // one parse step
  always_comb begin
    ph0  = r_first ? ntlv_pkg::PH_TAG : phase;
    pos0 = r_first ? '0 : pos;
    tag0 = r_first ? '0 : tag;
    lh0  = r_first ? '0 : lh;
    vr0  = r_first ? '0 : vr;
    fl0  = r_first ? '0 : fl;

    phase_next = ph0;
    pos_next   = pos0;
    tag_next   = tag0;
    lh_next    = lh0;
    vr_next    = vr0;
    fl_next    = fl0;

    nxt     = POS_W'(pos0 + 1'b1);
    vr_dec  = (vr0 != '0) ? POS_W'(vr0 - 1'b1) : vr0;
    len_sel = (ph0 == ntlv_pkg::PH_LEN_LO) ? {lh0, r_byte} : {8'h00, r_byte};
    // value must end inside the area
    over    = (17'(len_sel) + 17'(nxt)) > 17'(lim);

    len_go    = 1'b0;
    emit_byte = 1'b0;
    emit_stat = 1'b0;
    fin       = 1'b0;
    stat      = ntlv_pkg::STAT_NONE;

    if (ph0 != ntlv_pkg::PH_DONE) begin
      if (pos0 >= lim) begin
        emit_stat = 1'b1;
        fin       = 1'b1;
      end else begin
        pos_next = nxt;
        case (ph0)
          ntlv_pkg::PH_TAG: begin
            if (r_byte == ntlv_pkg::TAG_TERM) begin
              emit_stat = 1'b1;
              fin       = 1'b1;
            end else if (r_byte != ntlv_pkg::TAG_NULL) begin
              tag_next   = r_byte;
              phase_next = ntlv_pkg::PH_LEN;
            end
          end
          ntlv_pkg::PH_LEN: begin
            if (r_byte == ntlv_pkg::LEN_LONG) begin
              phase_next = ntlv_pkg::PH_LEN_HI;
            end else begin
              len_go = 1'b1;
            end
          end
          ntlv_pkg::PH_LEN_HI: begin
            lh_next    = r_byte;
            phase_next = ntlv_pkg::PH_LEN_LO;
          end
          ntlv_pkg::PH_LEN_LO: begin
            len_go = 1'b1;
          end
          ntlv_pkg::PH_SKIP: begin
            vr_next = vr_dec;
            if (vr_dec == '0) phase_next = ntlv_pkg::PH_TAG;
          end
          ntlv_pkg::PH_MSG: begin
            emit_byte = 1'b1;
            vr_next   = vr_dec;
            if (vr_dec == '0) begin
              emit_stat = 1'b1;
              stat      = ntlv_pkg::STAT_FOUND;
              fin       = 1'b1;
            end
          end
          default: begin
            phase_next = ntlv_pkg::PH_DONE;
            fin        = 1'b1;
          end
        endcase

        // length complete
        if (len_go) begin
          if (over) begin
            emit_stat = 1'b1;
            stat      = ntlv_pkg::STAT_TRUNC;
            fin       = 1'b1;
          end else if (tag0 == ntlv_pkg::TAG_NDEF) begin
            fl_next = len_sel[POS_W-1:0];
            if (len_sel == 16'd0) begin
              emit_stat = 1'b1;
              stat      = ntlv_pkg::STAT_FOUND;
              fin       = 1'b1;
            end else begin
              vr_next    = len_sel[POS_W-1:0];
              phase_next = ntlv_pkg::PH_MSG;
            end
          end else if (len_sel == 16'd0) begin
            phase_next = ntlv_pkg::PH_TAG;
          end else begin
            vr_next    = len_sel[POS_W-1:0];
            phase_next = ntlv_pkg::PH_SKIP;
          end
        end

        // area ends on this byte
        if (!fin && nxt >= lim) begin
          emit_stat = 1'b1;
          stat      = (phase_next == ntlv_pkg::PH_TAG) ? ntlv_pkg::STAT_NONE
                                                       : ntlv_pkg::STAT_TRUNC;
        end
      end
    end

    if (emit_stat) phase_next = ntlv_pkg::PH_DONE;

    byte_r.kind   = ntlv_pkg::KIND_BYTE;
    byte_r.mbyte  = r_byte;
    byte_r.status = ntlv_pkg::STAT_FOUND;
    byte_r.length = '0;
    byte_r.last   = 1'b0;

    stat_r.kind   = ntlv_pkg::KIND_STATUS;
    stat_r.mbyte  = '0;
    stat_r.status = stat;
    stat_r.length = (stat == ntlv_pkg::STAT_FOUND) ? ntlv_pkg::LEN_W'(fl_next) : '0;
    stat_r.last   = 1'b1;

    push.n  = go ? (2'(emit_byte) + 2'(emit_stat)) : 2'd0;
    push.r0 = emit_byte ? byte_r : stat_r;
    push.r1 = stat_r;
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= ntlv_pkg::PH_TAG;
      pos   <= '0;
      tag   <= '0;
      lh    <= '0;
      vr    <= '0;
      fl    <= '0;
    end else if (go) begin
      phase <= phase_next;
      pos   <= pos_next;
      tag   <= tag_next;
      lh    <= lh_next;
      vr    <= vr_next;
      fl    <= fl_next;
    end
  end

  // two results only when a message byte closes the message
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    push.n == 2'd2 |-> push.r0.kind == ntlv_pkg::KIND_BYTE &&
                       push.r1.kind == ntlv_pkg::KIND_STATUS)
    else $error("result pair out of order");

  // a finished area stays silent until restarted
  a_done_quiet: assert property (@(posedge clk) disable iff (rst)
    go && phase == ntlv_pkg::PH_DONE && !r_first |-> push.n == 2'd0)
    else $error("result after final status");

  // a status result closes the area
  a_status_done: assert property (@(posedge clk) disable iff (rst)
    go && emit_stat |=> phase == ntlv_pkg::PH_DONE)
    else $error("status without closing the area");

endmodule

>>> rtl/ntlv_outq.sv
module ntlv_outq (
  input  logic              clk,
  input  logic              rst,
  input  ntlv_pkg::push_t   push,
  output logic              room,
  output logic              result_valid,
  input  logic              result_stall,
  output ntlv_pkg::result_t head
);

  ntlv_pkg::result_t               mem [ntlv_pkg::QDEPTH];
  logic [ntlv_pkg::QPTR_W-1:0]     wr, rd;
  logic [ntlv_pkg::QCNT_W-1:0]     count, count_next;
  logic                            pop;

  assign result_valid = (count != '0);
  assign pop          = result_valid && !result_stall;
  assign head         = mem[rd];
  // worst case push is two beats
  assign room         = count <= ntlv_pkg::QCNT_W'(ntlv_pkg::QDEPTH - 2);
  assign count_next   = count + ntlv_pkg::QCNT_W'(push.n) - ntlv_pkg::QCNT_W'(pop);

  // pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr    <= '0;
      rd    <= '0;
      count <= '0;
    end else begin
      wr    <= wr + ntlv_pkg::QPTR_W'(push.n);
      rd    <= rd + ntlv_pkg::QPTR_W'(pop);
      count <= count_next;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem[wr] <= push.r0;
    if (push.n == 2'd2) mem[ntlv_pkg::QPTR_W'(wr + 1'b1)] <= push.r1;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= ntlv_pkg::QCNT_W'(ntlv_pkg::QDEPTH))
    else $error("output queue overflow");

endmodule

>>> rtl/ndef_tlv_message_extract_top.sv
// NDEF message TLV extractor.
// Item channel: item_valid/item_stall with data_byte and first_of_area, one
// byte of the tag data area per beat; first_of_area restarts the scan.
// Result channel: result_valid/result_stall with result_kind, message_byte,
// status, message_length and last. Message value bytes come out as kind-0
// beats, then exactly one kind-1 status beat with last set closes the area.
// Config channel: cfg_valid/cfg_ready (ready always high) writes area_length;
// write it only while no bytes are in flight.
// Path: the input register feeds a combinational parse step, whose results
// are written into a four-entry result queue. Throughput: one byte per cycle
// while the queue has room. The byte that ends a message yields two results
// and can raise item_stall when the queue is filling.
// Reset: area_length returns to 96, the parser expects a tag at position
// zero and the queue empties. A stalled receiver fills the queue, and then
// item_stall rises and holds the input register until room returns.
module ndef_tlv_message_extract_top #(
  parameter int MAX_AREA_BYTES = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ntlv_pkg::LEN_W-1:0]   area_length,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  logic [ntlv_pkg::BYTE_W-1:0]  data_byte,
  input  logic                         first_of_area,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic                         result_kind,
  output logic [ntlv_pkg::BYTE_W-1:0]  message_byte,
  output logic [ntlv_pkg::STAT_W-1:0]  status,
  output logic [ntlv_pkg::LEN_W-1:0]   message_length,
  output logic                         last
);

  // largest usable area: limited by the parameter and the register width
  localparam int REG_MAX = (1 << ntlv_pkg::LEN_W) - 1;
  localparam int LIM_MAX = (MAX_AREA_BYTES < REG_MAX) ? MAX_AREA_BYTES : REG_MAX;
  localparam int POS_W   = $clog2(LIM_MAX + 1);
  localparam int LIM_RST = (ntlv_pkg::AREA_RESET > LIM_MAX) ? LIM_MAX
                                                            : ntlv_pkg::AREA_RESET;

  logic [POS_W-1:0]  lim;
  logic              room;
  ntlv_pkg::push_t   push;
  ntlv_pkg::result_t head;

  assign cfg_ready = 1'b1;

  // area length register, held already clamped
  always_ff @(posedge clk) begin
    if (rst) begin
      lim <= POS_W'(LIM_RST);
    end else if (cfg_valid && cfg_ready) begin
      lim <= (area_length > ntlv_pkg::LEN_W'(LIM_MAX)) ? POS_W'(LIM_MAX)
                                                       : area_length[POS_W-1:0];
    end
  end

  ntlv_parse #(
    .POS_W(POS_W)
  ) u_parse (
    .clk          (clk),
    .rst          (rst),
    .lim          (lim),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .data_byte    (data_byte),
    .first_of_area(first_of_area),
    .room         (room),
    .push         (push)
  );

  ntlv_outq u_outq (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .room        (room),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .head        (head)
  );

  assign result_kind    = head.kind;
  assign message_byte   = head.mbyte;
  assign status         = head.status;
  assign message_length = head.length;
  assign last           = head.last;

endmodule

>>> tb/ndef_tlv_message_extract_top_tb.sv
module ndef_tlv_message_extract_top_tb;

  localparam int MAX_AREA     = 4096;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_BYTES = 400;

  // one row of the directed byte table
  typedef struct packed {
    bit                          wr;
    logic [ntlv_pkg::LEN_W-1:0]  area;
    bit                          first;
    logic [ntlv_pkg::BYTE_W-1:0] data;
    bit                          typed;
    logic [ntlv_pkg::STAT_W-1:0] st;
  } tlv_row_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [ntlv_pkg::LEN_W-1:0]    area_length = ntlv_pkg::LEN_W'(ntlv_pkg::AREA_RESET);
  logic                          item_valid = 1'b0;
  logic                          item_stall;
  logic [ntlv_pkg::BYTE_W-1:0]   data_byte = '0;
  logic                          first_of_area = 1'b0;
  logic                          result_valid;
  logic                          result_stall = 1'b0;
  logic                          result_kind;
  logic [ntlv_pkg::BYTE_W-1:0]   message_byte;
  logic [ntlv_pkg::STAT_W-1:0]   status;
  logic [ntlv_pkg::LEN_W-1:0]    message_length;
  logic                          last;

  // scanner state mirrored by the predictor
  ntlv_pkg::phase_t              scan_ph;
  logic [ntlv_pkg::LEN_W-1:0]    scan_pos;
  logic [ntlv_pkg::BYTE_W-1:0]   scan_tag;
  logic [ntlv_pkg::BYTE_W-1:0]   scan_len_hi;
  logic [15:0]                   scan_left;
  logic [ntlv_pkg::LEN_W-1:0]    scan_found;
  logic [ntlv_pkg::LEN_W-1:0]    area_cfg;

  ntlv_pkg::result_t             step_res[$];
  ntlv_pkg::result_t             pending_results[$];
  ntlv_pkg::result_t             want;
  tlv_row_t                      byte_table[$];
  logic [ntlv_pkg::BYTE_W-1:0]   area_bytes[$];

  int unsigned cycles = 0;
  int unsigned errors = 0;
  int unsigned bytes_sent = 0;
  int unsigned bytes_parsed = 0;
  int unsigned area_writes = 0;
  int unsigned msg_bytes_seen = 0;
  int unsigned found_seen = 0;
  int unsigned none_seen = 0;
  int unsigned trunc_seen = 0;
  int unsigned burst_left = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;

  ndef_tlv_message_extract_top #(
    .MAX_AREA_BYTES(MAX_AREA)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .area_length(area_length),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .data_byte(data_byte),
    .first_of_area(first_of_area),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_kind(result_kind),
    .message_byte(message_byte),
    .status(status),
    .message_length(message_length),
    .last(last)
  );

  always #2 clk = ~clk;

  // ---------------- predictor ----------------

  // close the area with a status beat
  function automatic void post_status(logic [ntlv_pkg::STAT_W-1:0] st);
    ntlv_pkg::result_t r;
    r.kind   = ntlv_pkg::KIND_STATUS;
    r.mbyte  = '0;
    r.status = st;
    r.length = (st == ntlv_pkg::STAT_FOUND) ? scan_found : '0;
    r.last   = 1'b1;
    step_res.push_back(r);
    scan_ph = ntlv_pkg::PH_DONE;
  endfunction

  // length fully known: value must end inside the area
  function automatic void close_length(int unsigned len, int unsigned start,
                                       int unsigned lim);
    if (start + len > lim) begin
      post_status(ntlv_pkg::STAT_TRUNC);
    end else if (scan_tag == ntlv_pkg::TAG_NDEF) begin
      scan_found = len[ntlv_pkg::LEN_W-1:0];
      if (len == 0) begin
        post_status(ntlv_pkg::STAT_FOUND);
      end else begin
        scan_left = len[15:0];
        scan_ph   = ntlv_pkg::PH_MSG;
      end
    end else if (len == 0) begin
      scan_ph = ntlv_pkg::PH_TAG;
    end else begin
      scan_left = len[15:0];
      scan_ph   = ntlv_pkg::PH_SKIP;
    end
  endfunction

  // one accepted byte; results go to step_res, returns 1 if the byte was parsed
  function automatic bit tlv_step(logic [ntlv_pkg::BYTE_W-1:0] b, logic first);
    int unsigned       lim;
    int unsigned       nxt;
    ntlv_pkg::result_t r;
    lim = (area_cfg > MAX_AREA) ? MAX_AREA : area_cfg;
    if (first) begin
      scan_ph     = ntlv_pkg::PH_TAG;
      scan_pos    = '0;
      scan_tag    = '0;
      scan_len_hi = '0;
      scan_left   = '0;
      scan_found  = '0;
    end
    if (scan_ph == ntlv_pkg::PH_DONE) return 1'b0;
    if (scan_pos >= lim) begin
      post_status(ntlv_pkg::STAT_NONE);
      return 1'b1;
    end
    nxt = scan_pos + 1;
    scan_pos = nxt[ntlv_pkg::LEN_W-1:0];
    case (scan_ph)
      ntlv_pkg::PH_TAG: begin
        if (b == ntlv_pkg::TAG_TERM) begin
          post_status(ntlv_pkg::STAT_NONE);
        end else if (b != ntlv_pkg::TAG_NULL) begin
          scan_tag = b;
          scan_ph  = ntlv_pkg::PH_LEN;
        end
      end
      ntlv_pkg::PH_LEN: begin
        if (b == ntlv_pkg::LEN_LONG) scan_ph = ntlv_pkg::PH_LEN_HI;
        else close_length(32'(b), nxt, lim);
      end
      ntlv_pkg::PH_LEN_HI: begin
        scan_len_hi = b;
        scan_ph     = ntlv_pkg::PH_LEN_LO;
      end
      ntlv_pkg::PH_LEN_LO: begin
        close_length(32'({scan_len_hi, b}), nxt, lim);
      end
      ntlv_pkg::PH_SKIP: begin
        if (scan_left > 0) scan_left = scan_left - 16'd1;
        if (scan_left == 0) scan_ph = ntlv_pkg::PH_TAG;
      end
      ntlv_pkg::PH_MSG: begin
        r.kind   = ntlv_pkg::KIND_BYTE;
        r.mbyte  = b;
        r.status = ntlv_pkg::STAT_FOUND;
        r.length = '0;
        r.last   = 1'b0;
        step_res.push_back(r);
        if (scan_left > 0) scan_left = scan_left - 16'd1;
        if (scan_left == 0) post_status(ntlv_pkg::STAT_FOUND);
      end
      default: begin
        scan_ph = ntlv_pkg::PH_DONE;
      end
    endcase
    if (scan_ph == ntlv_pkg::PH_DONE) return 1'b1;
    // area runs out: clean between TLVs, truncated inside one
    if (nxt >= lim) begin
      post_status((scan_ph == ntlv_pkg::PH_TAG) ? ntlv_pkg::STAT_NONE
                                                : ntlv_pkg::STAT_TRUNC);
    end
    return 1'b1;
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic void add_row(bit wr, logic [ntlv_pkg::LEN_W-1:0] area, bit first,
                                  logic [ntlv_pkg::BYTE_W-1:0] data, bit typed,
                                  logic [ntlv_pkg::STAT_W-1:0] st);
    tlv_row_t row;
    row.wr    = wr;
    row.area  = area;
    row.first = first;
    row.data  = data;
    row.typed = typed;
    row.st    = st;
    byte_table.push_back(row);
  endfunction

  function automatic void push_tlv(logic [ntlv_pkg::BYTE_W-1:0] t, int unsigned len,
                                   bit long_len);
    area_bytes.push_back(t);
    if (long_len || len > 255) begin
      area_bytes.push_back(ntlv_pkg::LEN_LONG);
      area_bytes.push_back(len[15:8]);
      area_bytes.push_back(len[7:0]);
    end else begin
      area_bytes.push_back(len[7:0]);
    end
    repeat (len) area_bytes.push_back(ntlv_pkg::BYTE_W'($urandom));
  endfunction

  function automatic logic [ntlv_pkg::BYTE_W-1:0] plain_tag();
    logic [ntlv_pkg::BYTE_W-1:0] t;
    do t = ntlv_pkg::BYTE_W'($urandom);
    while (t == ntlv_pkg::TAG_NULL || t == ntlv_pkg::TAG_TERM || t == ntlv_pkg::TAG_NDEF);
    return t;
  endfunction

  // mostly well-formed TLV areas with random content and a bit of junk
  function automatic void build_area(int unsigned lim);
    int unsigned target;
    int unsigned len;
    bit          done;
    area_bytes.delete();
    target = (lim <= 64) ? lim : $urandom_range(8, 48);
    done = 1'b0;
    while (!done && area_bytes.size() < target) begin
      case ($urandom_range(0, 11))
        0, 1: area_bytes.push_back(ntlv_pkg::TAG_NULL);
        2, 3, 4: push_tlv(plain_tag(), $urandom_range(0, 6), $urandom_range(0, 3) == 0);
        5, 6, 7: begin
          // now and then a long message in a big area
          if (lim > 1000 && $urandom_range(0, 7) == 0) len = $urandom_range(256, 300);
          else len = $urandom_range(0, 10);
          push_tlv(ntlv_pkg::TAG_NDEF, len, $urandom_range(0, 3) == 0);
          done = 1'b1;
        end
        8: begin
          area_bytes.push_back(ntlv_pkg::TAG_TERM);
          done = 1'b1;
        end
        9: area_bytes.push_back(ntlv_pkg::BYTE_W'($urandom));
        default: begin
          // length that likely overruns the area
          area_bytes.push_back(($urandom_range(0, 1) == 0) ? ntlv_pkg::TAG_NDEF
                                                           : plain_tag());
          if ($urandom_range(0, 1) == 0) begin
            area_bytes.push_back(ntlv_pkg::LEN_LONG);
            area_bytes.push_back(ntlv_pkg::BYTE_W'($urandom));
          end
          area_bytes.push_back(ntlv_pkg::BYTE_W'($urandom));
          done = 1'b1;
        end
      endcase
    end
    repeat ($urandom_range(0, 3)) area_bytes.push_back(ntlv_pkg::BYTE_W'($urandom));
  endfunction

  // sender bursts with random gaps between them
  task automatic pace();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // one byte beat; prediction taken at the accepting edge
  task automatic send_item(input bit first, input logic [ntlv_pkg::BYTE_W-1:0] b,
                           input bit typed, input ntlv_pkg::result_t typed_res,
                           output bit parsed);
    item_valid    <= 1'b1;
    data_byte     <= b;
    first_of_area <= first;
    do @(posedge clk); while (item_stall);
    step_res.delete();
    parsed = tlv_step(b, first);
    if (typed) pending_results.push_back(typed_res);
    else foreach (step_res[i]) pending_results.push_back(step_res[i]);
    bytes_sent++;
    if (parsed) bytes_parsed++;
  endtask

  // stop sending until every expected beat is back, then let the pipe empty
  task automatic settle();
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_area(logic [ntlv_pkg::LEN_W-1:0] v);
    cfg_valid   <= 1'b1;
    area_length <= v;
    do @(posedge clk); while (!cfg_ready);
    area_cfg = v;
    cfg_valid <= 1'b0;
    area_writes++;
  endtask

  // ---------------- main sequence ----------------
  initial begin
    ntlv_pkg::result_t          fixed;
    bit                         parsed;
    int unsigned                phase_no;
    int unsigned                phase_parsed;
    int unsigned                eff;
    int unsigned                n;
    logic [ntlv_pkg::LEN_W-1:0] v;

    area_cfg    = ntlv_pkg::LEN_W'(ntlv_pkg::AREA_RESET);
    scan_ph     = ntlv_pkg::PH_TAG;
    scan_pos    = '0;
    scan_tag    = '0;
    scan_len_hi = '0;
    scan_left   = '0;
    scan_found  = '0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset length 96; no area start right after reset
    add_row(0, 0, 0, 8'h00, 0, ntlv_pkg::STAT_FOUND);
    add_row(0, 0, 0, ntlv_pkg::TAG_TERM, 1, ntlv_pkg::STAT_NONE);
    add_row(0, 0, 0, 8'h55, 0, ntlv_pkg::STAT_FOUND);      // ignored after status
    // empty message
    add_row(0, 0, 1, ntlv_pkg::TAG_NDEF, 0, ntlv_pkg::STAT_FOUND);
    add_row(0, 0, 0, 8'h00, 1, ntlv_pkg::STAT_FOUND);
    // skipped TLV, then a long-length message of three bytes
    add_row(0, 0, 1, 8'h01, 0, ntlv_pkg::STAT_FOUND);
    add_row(0, 0, 0, 8'h02, 0, ntlv_pkg::STAT_FOUND);
    add_row(0, 0, 0, 8'hAA, 0, ntlv_pkg::STAT_FOUND);
    add_row(0, 0, 0, 8'hBB, 0, ntlv_pkg::STAT_FOUND);
    add_row(0, 0, 0, ntlv_pkg::TAG_NDEF, 0, ntlv_pkg::STAT_FOUND);
    add_row(0, 0, 0, ntlv_pkg::LEN_LONG, 0, ntlv_pkg::STAT_FOUND);
    add_row(0, 0, 0, 8'h00, 0, ntlv_pkg::STAT_FOUND);
    add_row(0, 0, 0, 8'h03, 0, ntlv_pkg::STAT_FOUND);
    add_row(0, 0, 0, 8'h00, 0, ntlv_pkg::STAT_FOUND);
    add_row(0, 0, 0, 8'hFF, 0, ntlv_pkg::STAT_FOUND);
    add_row(0, 0, 0, 8'h80, 0, ntlv_pkg::STAT_FOUND);
    // value past end, long and short length
    add_row(0, 0, 1, 8'hFF, 0, ntlv_pkg::STAT_FOUND);
    add_row(0, 0, 0, ntlv_pkg::LEN_LONG, 0, ntlv_pkg::STAT_FOUND);
    add_row(0, 0, 0, 8'h10, 0, ntlv_pkg::STAT_FOUND);
    add_row(0, 0, 0, 8'h00, 1, ntlv_pkg::STAT_TRUNC);
    add_row(0, 0, 1, ntlv_pkg::TAG_NDEF, 0, ntlv_pkg::STAT_FOUND);
    add_row(0, 0, 0, 8'h61, 1, ntlv_pkg::STAT_TRUNC);
    // zero-length area
    add_row(1, 13'd0, 1, 8'h42, 1, ntlv_pkg::STAT_NONE);
    // one-byte area: tag as last byte, then clean end
    add_row(1, 13'd1, 1, ntlv_pkg::TAG_NDEF, 1, ntlv_pkg::STAT_TRUNC);
    add_row(0, 0, 1, ntlv_pkg::TAG_NULL, 1, ntlv_pkg::STAT_NONE);
    // long length that does not fit
    add_row(1, 13'd3, 1, 8'h01, 0, ntlv_pkg::STAT_FOUND);
    add_row(0, 0, 0, ntlv_pkg::LEN_LONG, 0, ntlv_pkg::STAT_FOUND);
    add_row(0, 0, 0, 8'h00, 1, ntlv_pkg::STAT_TRUNC);

    foreach (byte_table[i]) begin
      if (byte_table[i].wr) begin
        settle();
        write_area(byte_table[i].area);
      end
      fixed.kind   = ntlv_pkg::KIND_STATUS;
      fixed.mbyte  = '0;
      fixed.status = byte_table[i].st;
      fixed.length = '0;
      fixed.last   = 1'b1;
      pace();
      send_item(byte_table[i].first, byte_table[i].data, byte_table[i].typed, fixed, parsed);
    end

    // random areas over a series of length settings
    phase_no = 0;
    while (bytes_parsed < RANDOM_BYTES + byte_table.size()) begin
      case (phase_no)
        0: v = 13'd8191;
        1: v = 13'd4096;
        2: v = 13'd2;
        3: v = 13'd24;
        4: v = 13'd64;
        5: v = 13'd7;
        default: v = ntlv_pkg::LEN_W'($urandom_range(1, 100));
      endcase
      settle();
      write_area(v);
      eff = (v > MAX_AREA) ? MAX_AREA : v;
      phase_parsed = bytes_parsed;
      while (bytes_parsed - phase_parsed < 60) begin
        build_area(eff);
        n = area_bytes.size();
        if ($urandom_range(0, 7) == 0) n = $urandom_range(1, n);   // cut short
        for (int unsigned i = 0; i < n; i++) begin
          pace();
          send_item((i == 0) && ($urandom_range(0, 9) != 0), area_bytes[i], 0, fixed, parsed);
        end
      end
      phase_no++;
    end

    settle();
    repeat (8) @(posedge clk);
    $display("Sent %0d bytes (%0d parsed) over %0d area-length settings.",
             bytes_sent, bytes_parsed, area_writes);
    $display("Saw %0d message bytes; areas found %0d, none %0d, truncated %0d.",
             msg_bytes_seen, found_seen, none_seen, trunc_seen);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // ---------------- receiver ----------------

  // stall pattern: random stretches of none, light, half and heavy stall
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left   <= 0;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_left <= $urandom_range(8, 60);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0: result_stall <= 1'b0;
        1: result_stall <= ($urandom_range(0, 3) == 0);
        2: result_stall <= 1'($urandom_range(0, 1));
        default: result_stall <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  task automatic check_field(string name, int unsigned exp_v, int unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      errors++;
    end
  endtask

  // compare each accepted result beat with the oldest expectation
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: kind %0d byte %0d status %0d",
               result_kind, message_byte, status);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("result_kind", want.kind, result_kind);
        check_field("message_byte", want.mbyte, message_byte);
        check_field("status", want.status, status);
        check_field("message_length", want.length, message_length);
        check_field("last", want.last, last);
        if (want.kind == ntlv_pkg::KIND_BYTE) msg_bytes_seen++;
        else if (want.status == ntlv_pkg::STAT_FOUND) found_seen++;
        else if (want.status == ntlv_pkg::STAT_NONE) none_seen++;
        else trunc_seen++;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still pending",
               cycles, pending_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule
